@@ sv/bfha_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bfha_pkg
// Shared types and constants of the best-fit heap allocator.
// ---------------------------------------------------------------------------
package bfha_pkg;

  // Heap geometry
  localparam int HEAP_BYTES   = 8192;
  localparam int ALIGN_BYTES  = 8;
  localparam int HEADER_BYTES = 16;
  localparam int INFO_BYTES   = 16;

  localparam int OFF_W   = 13;                    // byte offset width
  localparam int ALN_SH  = 3;                     // log2 of alignment
  localparam int IDX_W   = OFF_W - ALN_SH;        // header slot index width
  localparam int SIZE_W  = 13;                    // stored payload size
  localparam int REQ_W   = 14;                    // rounded request size
  localparam int DEPTH   = HEAP_BYTES / ALIGN_BYTES;

  localparam logic [IDX_W-1:0]  INFO_IDX = IDX_W'(INFO_BYTES / ALIGN_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SIZE =
      SIZE_W'((HEAP_BYTES / ALIGN_BYTES) * ALIGN_BYTES - INFO_BYTES - HEADER_BYTES);
  localparam logic [REQ_W-1:0]  HDR_SZ = REQ_W'(HEADER_BYTES);

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOFIT  = 2'd1,
    ST_NULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_e;

  // One header slot
  typedef struct packed {
    logic              live;
    logic              used;
    logic [SIZE_W-1:0] size;
    logic [IDX_W-1:0]  prev;   // 0 means no previous block
  } hdr_t;

  // Header store port request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    hdr_t             wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

@@ sv/bfha_hdr_ram.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// bfha_hdr_ram
// Header store: one write port and one registered read port.
// ---------------------------------------------------------------------------
module bfha_hdr_ram (
  input  wire logic              clk_i,
  input  wire bfha_pkg::ram_req_t req_i,
  output bfha_pkg::hdr_t          rdata_o
);
  import bfha_pkg::*;

  hdr_t mem [DEPTH];

  // Write on request
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read every cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule
`default_nettype wire

@@ sv/best_fit_heap_allocator_unit.sv @@
`default_nettype none
// Flow: an allocate visits blocks on the walk back from the tail, then splits and marks;
//   a rejected free ends after its checks, and a valid free merges its free neighbors
//   before it writes back the merged block and fixes the back link of the next one.
// Throughput: one word at a time; the single header store port sets the pace.
// Reset: a clearing pass sweeps every header slot, then the heap is one free block.
// Results wait in an output register while the next word is taken.
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_unit
// Best-fit heap allocator with coalescing, run by a small sequencer over one
// header store port.
// ---------------------------------------------------------------------------
module best_fit_heap_allocator_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,   // alloc_size[13:0], free_addr[26:14]
  input  wire logic        s_axis_tuser_i,   // mode[0]
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [15:0] m_axis_tdata_o    // status[1:0], block_addr[14:2]
);
  import bfha_pkg::*;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_AW_EV  = 13'b0000000000100,
    S_A_PLAN = 13'b0000000001000,
    S_A_NXWR = 13'b0000000010000,
    S_A_BEST = 13'b0000000100000,
    S_F_CHK  = 13'b0000001000000,
    S_F_PEV  = 13'b0000010000000,
    S_F_FWD  = 13'b0000100000000,
    S_F_NEV  = 13'b0001000000000,
    S_F_WB   = 13'b0010000000000,
    S_F_LNK  = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic [IDX_W-1:0]  tail_q, tail_d;
  logic [REQ_W-1:0]  req_q, req_d;
  logic [IDX_W-1:0]  cur_q, cur_d;       // walk pointer / block being freed
  logic              best_v_q, best_v_d;
  logic [IDX_W-1:0]  best_q, best_d;
  logic [SIZE_W-1:0] bsize_q, bsize_d;   // best size / merged size
  logic [IDX_W-1:0]  bprev_q, bprev_d;
  logic [IDX_W-1:0]  n_q, n_d;
  logic [IDX_W-1:0]  nx_q, nx_d;
  status_e           st_q, st_d;
  logic [OFF_W-1:0]  addr_q, addr_d;
  logic              ovld_q, ovld_d;
  logic [15:0]       odata_q, odata_d;

  ram_req_t ram_req;
  hdr_t     rd;

  bfha_hdr_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rd)
  );

  // Input word fields
  logic              in_mode;
  logic [13:0]       in_size;
  logic [OFF_W-1:0]  in_faddr;
  logic [REQ_W:0]    req_round;
  logic [OFF_W-1:0]  faddr_hdr;
  assign in_mode   = s_axis_tuser_i;
  assign in_size   = s_axis_tdata_i[13:0];
  assign in_faddr  = s_axis_tdata_i[26:14];
  assign req_round = ({1'b0, in_size} + (REQ_W + 1)'(ALIGN_BYTES - 1))
                     & ~(REQ_W + 1)'(ALIGN_BYTES - 1);
  assign faddr_hdr = in_faddr - OFF_W'(HEADER_BYTES);

  // Shared offset adder: slot offset + header + size, as a slot index
  logic [IDX_W-1:0] add_idx;
  logic [REQ_W-1:0] add_size;
  logic [REQ_W:0]   add_sum;
  logic [IDX_W-1:0] add_res;
  assign add_sum = (REQ_W + 1)'({add_idx, {ALN_SH{1'b0}}}) + (REQ_W + 1)'(HDR_SZ)
                   + (REQ_W + 1)'(add_size);
  assign add_res = add_sum[ALN_SH +: IDX_W];

  logic             fit;
  logic [REQ_W-1:0] slack;
  assign fit   = rd.live && !rd.used && ({1'b0, rd.size} >= req_q)
                 && (!best_v_q || (bsize_q > rd.size));
  assign slack = {1'b0, bsize_q} - req_q;

  assign s_axis_tready_o = (state_q == S_IDLE);

  // Sequencer
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    tail_d   = tail_q;
    req_d    = req_q;
    cur_d    = cur_q;
    best_v_d = best_v_q;
    best_d   = best_q;
    bsize_d  = bsize_q;
    bprev_d  = bprev_q;
    n_d      = n_q;
    nx_d     = nx_q;
    st_d     = st_q;
    addr_d   = addr_q;
    ovld_d   = ovld_q;
    odata_d  = odata_q;
    add_idx  = cur_q;
    add_size = REQ_W'(bsize_q);
    ram_req  = '0;

    // drop the result once taken
    if (m_axis_tready_i) begin
      ovld_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
        if (clr_q == INFO_IDX) begin
          ram_req.wdata = '{live: 1'b1, used: 1'b0, size: INIT_SIZE, prev: '0};
        end
        clr_d = clr_q + IDX_W'(1);
        if (clr_q == {IDX_W{1'b1}}) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_axis_tvalid_i) begin
          addr_d = '0;
          if (!in_mode) begin
            // a request that rounds past the size range can never fit
            req_d         = req_round[REQ_W] ? {REQ_W{1'b1}} : req_round[REQ_W-1:0];
            cur_d         = tail_q;
            best_v_d      = 1'b0;
            ram_req.raddr = tail_q;
            state_d       = S_AW_EV;
          end else if (in_faddr == '0) begin
            st_d    = ST_NULL;
            state_d = S_DONE;
          end else if ((in_faddr < OFF_W'(HEADER_BYTES))
                       || (faddr_hdr[ALN_SH-1:0] != '0)) begin
            st_d    = ST_UNUSED;
            state_d = S_DONE;
          end else begin
            cur_d         = faddr_hdr[OFF_W-1:ALN_SH];
            ram_req.raddr = faddr_hdr[OFF_W-1:ALN_SH];
            state_d       = S_F_CHK;
          end
        end
      end
      // walk back from the tail, keep the smallest fit
      S_AW_EV: begin
        if (fit) begin
          best_v_d = 1'b1;
          best_d   = cur_q;
          bsize_d  = rd.size;
          bprev_d  = rd.prev;
        end
        if (!rd.live || (fit && ({1'b0, rd.size} == req_q)) || (rd.prev == '0)) begin
          state_d = S_A_PLAN;
        end else begin
          cur_d         = rd.prev;
          ram_req.raddr = rd.prev;
        end
      end
      // report no fit if none was found; split the chosen block when the remainder exceeds a header
      S_A_PLAN: begin
        if (!best_v_q) begin
          st_d    = ST_NOFIT;
          state_d = S_DONE;
        end else if (slack > HDR_SZ) begin
          add_idx       = best_q;
          add_size      = req_q;
          n_d           = add_res;
          ram_req.we    = 1'b1;
          ram_req.waddr = add_res;
          ram_req.wdata = '{live: 1'b1, used: 1'b0,
                            size: SIZE_W'(slack - HDR_SZ), prev: best_q};
          bsize_d       = SIZE_W'(req_q);
          if (best_q != tail_q) begin
            nx_d          = best_q + IDX_W'((HEADER_BYTES / ALIGN_BYTES))
                            + IDX_W'(bsize_q >> ALN_SH);
            ram_req.raddr = best_q + IDX_W'((HEADER_BYTES / ALIGN_BYTES))
                            + IDX_W'(bsize_q >> ALN_SH);
            state_d       = S_A_NXWR;
          end else begin
            tail_d  = add_res;
            state_d = S_A_BEST;
          end
        end else begin
          state_d = S_A_BEST;
        end
      end
      S_A_NXWR: begin
        ram_req.we         = 1'b1;
        ram_req.waddr      = nx_q;
        ram_req.wdata      = rd;
        ram_req.wdata.prev = n_q;
        state_d            = S_A_BEST;
      end
      S_A_BEST: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = best_q;
        ram_req.wdata = '{live: 1'b1, used: 1'b1, size: bsize_q, prev: bprev_q};
        addr_d        = {best_q, {ALN_SH{1'b0}}} + OFF_W'(HEADER_BYTES);
        st_d          = ST_OK;
        state_d       = S_DONE;
      end
      // check the freed block, mark it unused
      S_F_CHK: begin
        if (!rd.live || !rd.used) begin
          st_d    = ST_UNUSED;
          state_d = S_DONE;
        end else begin
          bsize_d            = rd.size;
          bprev_d            = rd.prev;
          ram_req.we         = 1'b1;
          ram_req.waddr      = cur_q;
          ram_req.wdata      = rd;
          ram_req.wdata.used = 1'b0;
          if (rd.prev != '0) begin
            ram_req.raddr = rd.prev;
            state_d       = S_F_PEV;
          end else begin
            state_d = S_F_FWD;
          end
        end
      end
      // move back over free predecessors
      S_F_PEV: begin
        if (rd.live && !rd.used) begin
          cur_d   = bprev_q;
          bsize_d = rd.size;
          bprev_d = rd.prev;
          if (rd.prev != '0) begin
            ram_req.raddr = rd.prev;
          end else begin
            state_d = S_F_FWD;
          end
        end else begin
          state_d = S_F_FWD;
        end
      end
      // absorb free successors
      S_F_FWD: begin
        if (cur_q == tail_q) begin
          state_d = S_F_WB;
        end else begin
          n_d           = add_res;
          ram_req.raddr = add_res;
          state_d       = S_F_NEV;
        end
      end
      S_F_NEV: begin
        if (rd.used || !rd.live) begin
          state_d = S_F_WB;
        end else begin
          bsize_d       = bsize_q + SIZE_W'(HEADER_BYTES) + rd.size;
          ram_req.we    = 1'b1;
          ram_req.waddr = n_q;
          ram_req.wdata = '0;
          if (n_q == tail_q) begin
            tail_d = cur_q;
          end
          state_d = S_F_FWD;
        end
      end
      S_F_WB: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = cur_q;
        ram_req.wdata = '{live: 1'b1, used: 1'b0, size: bsize_q, prev: bprev_q};
        st_d          = ST_OK;
        if (cur_q != tail_q) begin
          n_d           = add_res;
          ram_req.raddr = add_res;
          state_d       = S_F_LNK;
        end else begin
          state_d = S_DONE;
        end
      end
      // fix the back link of the next block
      S_F_LNK: begin
        ram_req.we         = 1'b1;
        ram_req.waddr      = n_q;
        ram_req.wdata      = rd;
        ram_req.wdata.prev = cur_q;
        state_d            = S_DONE;
      end
      S_DONE: begin
        if (!ovld_q || m_axis_tready_i) begin
          ovld_d  = 1'b1;
          odata_d = {1'b0, addr_q, st_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      tail_q  <= INFO_IDX;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      tail_q  <= tail_d;
      ovld_q  <= ovld_d;
    end
  end

  // Working and result registers
  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    cur_q    <= cur_d;
    best_v_q <= best_v_d;
    best_q   <= best_d;
    bsize_q  <= bsize_d;
    bprev_q  <= bprev_d;
    n_q      <= n_d;
    nx_q     <= nx_d;
    st_q     <= st_d;
    addr_q   <= addr_d;
    odata_q  <= odata_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = odata_q;

  // Checks
  a_tail_nonnull: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q != '0)
    else $error("tail points at the info area");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done step");

  a_addr_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[14:2] != '0)) |-> (m_axis_tdata_o[1:0] == ST_OK))
    else $error("block address given with a failing status");

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready_o)
    else $error("word accepted during the clearing pass");

endmodule
`default_nettype wire

@@ verif/best_fit_heap_allocator_unit_tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// best_fit_heap_allocator_unit_tb
// Drives allocate and free words into the heap allocator. A behavioral heap
// predicts each status and block address, and a scoreboard compares them in
// order with the words that come out.
// ---------------------------------------------------------------------------

// Predicted heap and in-order store of expected results
class heap_scoreboard;
  typedef struct {
    bit [12:0] size;
    bit [12:0] prev;
    bit        used;
    bit        live;
  } blk_t;

  blk_t      blk[8192];
  bit [12:0] tail;
  bit [1:0]  exp_status[$];
  bit [12:0] exp_addr[$];
  int        mismatches;
  int        live_addrs[$];

  function new();
    int end_off;
    end_off = (bfha_pkg::HEAP_BYTES / bfha_pkg::ALIGN_BYTES) * bfha_pkg::ALIGN_BYTES;
    foreach (blk[i]) blk[i] = '{0, 0, 0, 0};
    tail = bfha_pkg::INFO_BYTES;
    blk[bfha_pkg::INFO_BYTES] = '{end_off - bfha_pkg::INFO_BYTES - bfha_pkg::HEADER_BYTES,
                                  0, 0, 1};
    mismatches = 0;
  endfunction

  function bit is_block(int o);
    return o != 0 && o < bfha_pkg::HEAP_BYTES && blk[o].live;
  endfunction

  function int next_block(int o);
    int n;
    if (o == tail || !is_block(o)) return 0;
    n = o + bfha_pkg::HEADER_BYTES + blk[o].size;
    return is_block(n) ? n : 0;
  endfunction

  // Best fit from the tail; split when the remainder exceeds one header
  function bit [1:0] allocate(int asize, output int addr);
    int req, cur, best, steps, old, n, nx;
    req = ((asize + bfha_pkg::ALIGN_BYTES - 1) / bfha_pkg::ALIGN_BYTES) * bfha_pkg::ALIGN_BYTES;
    cur = tail; best = 0; steps = 0; addr = 0;
    while (is_block(cur) && steps < bfha_pkg::HEAP_BYTES / bfha_pkg::HEADER_BYTES + 2) begin
      if (!blk[cur].used && blk[cur].size >= req && (best == 0 || blk[best].size > blk[cur].size)) begin
        best = cur;
        if (blk[cur].size == req) break;
      end
      cur = blk[cur].prev;
      steps++;
    end
    if (best == 0) return bfha_pkg::ST_NOFIT;
    old = blk[best].size;
    if (old - req > bfha_pkg::HEADER_BYTES) begin
      n = best + bfha_pkg::HEADER_BYTES + req;
      if (n < bfha_pkg::HEAP_BYTES) begin
        blk[n] = '{old - req - bfha_pkg::HEADER_BYTES, best, 0, 1};
        if (best != tail) begin
          nx = best + bfha_pkg::HEADER_BYTES + old;
          if (is_block(nx)) blk[nx].prev = n;
        end else begin
          tail = n;
        end
        blk[best].size = req;
      end
    end
    blk[best].used = 1;
    addr = best + bfha_pkg::HEADER_BYTES;
    return bfha_pkg::ST_OK;
  endfunction

  // Release a block and merge it with free neighbors
  function bit [1:0] release_block(int addr);
    int b, p, n, steps;
    if (addr == 0) return bfha_pkg::ST_NULL;
    if (addr < bfha_pkg::HEADER_BYTES) return bfha_pkg::ST_UNUSED;
    b = addr - bfha_pkg::HEADER_BYTES;
    if (!is_block(b) || !blk[b].used) return bfha_pkg::ST_UNUSED;
    blk[b].used = 0;
    steps = 0;
    forever begin
      p = blk[b].prev;
      if (!is_block(p) || blk[p].used || steps >= 514) break;
      b = p; steps++;
    end
    steps = 0;
    forever begin
      n = next_block(b);
      if (n == 0 || blk[n].used || steps >= 514) break;
      blk[b].size = blk[b].size + bfha_pkg::HEADER_BYTES + blk[n].size;
      blk[n].live = 0;
      if (n == tail) tail = b;
      steps++;
    end
    n = next_block(b);
    if (n != 0) blk[n].prev = b;
    return bfha_pkg::ST_OK;
  endfunction

  // Note an accepted word and queue its expected result
  function void note_request(bit mode, int asize, int faddr);
    bit [1:0] st;
    int       a;
    a = 0;
    if (mode == 1'b0) begin
      st = allocate(asize, a);
      if (st == bfha_pkg::ST_OK) live_addrs.push_back(a);
    end else begin
      st = release_block(faddr);
      if (st == bfha_pkg::ST_OK)
        foreach (live_addrs[i]) if (live_addrs[i] == faddr) begin
          live_addrs.delete(i);
          break;
        end
    end
    exp_status.push_back(st);
    exp_addr.push_back(st == bfha_pkg::ST_OK ? a[12:0] : 13'd0);
  endfunction

  // Compare one result word with the oldest expectation
  function void check_result(bit [15:0] w);
    bit [1:0]  st;
    bit [12:0] a;
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result word %h", w);
      return;
    end
    st = exp_status.pop_front();
    a  = exp_addr.pop_front();
    if (w[1:0] != st || w[14:2] != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: status exp %0d got %0d, addr exp %0d got %0d",
                 st, w[1:0], a, w[14:2]);
    end
  endfunction
endclass

module best_fit_heap_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i;   // alloc_size[13:0], free_addr[26:14]
  logic        s_axis_tuser_i;   // mode[0]
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [15:0] m_axis_tdata_o;   // status[1:0], block_addr[14:2]

  heap_scoreboard heap_sb;
  int  cycle_count;
  bit  hold_off;
  bit  stim_done;

  best_fit_heap_allocator_unit u_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i, .s_axis_tready_o, .s_axis_tdata_i, .s_axis_tuser_i,
    .m_axis_tvalid_o, .m_axis_tready_i, .m_axis_tdata_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one word and wait for it to be taken
  task automatic send_word(bit mode, int asize, int faddr, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      @(posedge clk_i) s_axis_tvalid_i <= 1'b0;
      repeat (gap - 1) @(posedge clk_i);
    end
    @(posedge clk_i);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {5'd0, faddr[12:0], asize[13:0]};
    s_axis_tuser_i  <= mode;
    do @(posedge clk_i); while (!s_axis_tready_o);
    heap_sb.note_request(mode, asize, faddr);
  endtask

  task automatic idle_input();
    @(posedge clk_i) s_axis_tvalid_i <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    while (heap_sb.exp_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic int pick_live();
    if (heap_sb.live_addrs.size() == 0) return 0;
    return heap_sb.live_addrs[$urandom_range(0, heap_sb.live_addrs.size() - 1)];
  endfunction

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int stall;
    m_axis_tready_i = 1'b0;
    wait (rst_ni);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (hold_off) stall = 0;
      if (stall != 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      if (hold_off) begin
        m_axis_tready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      heap_sb.check_result(m_axis_tdata_o);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > 3000000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int a;
    heap_sb = new();
    hold_off = 0;
    stim_done = 0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: null, foreign, zero size, oversize, exact fit, double free
    send_word(1, 16383, 0);
    send_word(1, 0, 8);
    send_word(1, 0, 8191);
    send_word(0, 0, 0);
    send_word(0, 8192, 0);
    send_word(0, 16383, 8191);
    send_word(0, 8192 - 32, 0);
    send_word(1, 0, 32);
    send_word(1, 0, 32);
    send_word(0, 1, 0);
    send_word(0, 7, 0);
    send_word(0, 9, 0);
    send_word(0, 24, 0);
    a = heap_sb.live_addrs.size() > 0 ? heap_sb.live_addrs[0] : 0;
    send_word(1, 0, a);
    send_word(0, 24, 0);
    send_word(0, 20, 0);
    send_word(1, 0, a + 8);
    while (heap_sb.live_addrs.size() > 0) send_word(1, 0, heap_sb.live_addrs[0]);
    drain();

    // Fill while the receiver holds off
    hold_off = 1;
    for (int i = 0; i < 20; i++) send_word(0, $urandom_range(0, 64), 0, 1);
    drain();

    // Random mix: allocations and frees of live blocks, some noise
    for (int i = 0; i < 1500; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: send_word(0, $urandom_range(0, 1) ? $urandom_range(0, 256)
                                                     : $urandom_range(0, 16383),
                              $urandom_range(0, 8191));
        4, 5, 6, 7: send_word(1, $urandom_range(0, 16383), pick_live());
        8: send_word(1, $urandom_range(0, 16383), $urandom_range(0, 8191));
        default: send_word(0, $urandom_range(0, 2048), $urandom_range(0, 8191));
      endcase
      if (i == 750) drain();
    end
    stim_done = 1;
    drain();
    repeat (200) @(posedge clk_i);

    if (heap_sb.mismatches == 0 && heap_sb.exp_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

@@ best_fit_heap_allocator_unit.f @@
sv/bfha_pkg.sv
sv/bfha_hdr_ram.sv
sv/best_fit_heap_allocator_unit.sv
verif/best_fit_heap_allocator_unit_tb.sv
